>>> hdl/b64le_pkg.sv
// shared types, constants and the alphabet function of the base64 line encoder
`default_nettype none
package b64le_pkg;

  localparam int unsigned MaxChars = 6;
  localparam int unsigned CountW = 3;
  localparam int unsigned DefaultJobDepth = 2;
  localparam logic [7:0] DefaultLineLimit = 8'd76;

  localparam logic [1:0] GRP_FIRST = 2'd0;
  localparam logic [1:0] GRP_SECOND = 2'd1;
  localparam logic [1:0] GRP_THIRD = 2'd2;

  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
  } out_item_t;

  // all characters caused by one input byte, first character in slot 0
  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [CountW-1:0]        count;
  } job_t;

  // standard alphabet A-Z a-z 0-9 + /
  function automatic logic [7:0] b64_char(input logic [5:0] six);
    logic [7:0] v;
    v = {2'b00, six};
    if (six < 6'd26) begin
      return 8'h41 + v;
    end else if (six < 6'd52) begin
      return 8'h61 + (v - 8'd26);
    end else if (six < 6'd62) begin
      return 8'h30 + (v - 8'd52);
    end else if (six == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage
`default_nettype wire

>>> hdl/b64le_front.sv
// front end: takes bytes, tracks group and line state, builds one job per byte
`default_nettype none
module b64le_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire b64le_pkg::in_item_t in_item,
  input  wire logic               cfg_write,
  input  wire logic [7:0]         cfg_data,
  output b64le_pkg::job_t         job
);

  logic [1:0] group_position, group_position_next;
  logic [3:0] carry_bits, carry_bits_next;
  logic [7:0] line_length, line_length_next;
  logic [7:0] line_limit;

  logic [7:0] b;
  logic       fin;
  logic [7:0] grown_len;
  logic       brk;

  assign b = in_item.data_byte;
  assign fin = in_item.final_byte;
  assign grown_len = line_length + 8'd4;
  // break after a group once the grown length plus three reaches the limit
  assign brk = ({1'b0, grown_len} + 9'd3) >= {1'b0, line_limit};

  always_comb begin
    job.chars = '{default: b64le_pkg::CHAR_LF};
    job.chars[2] = b64le_pkg::CHAR_CR;
    job.chars[4] = b64le_pkg::CHAR_CR;
    job.count = b64le_pkg::CountW'(1);
    group_position_next = group_position;
    carry_bits_next = carry_bits;
    line_length_next = line_length;
    unique case (group_position)
      b64le_pkg::GRP_SECOND: begin
        job.chars[0] = b64le_pkg::b64_char({carry_bits[1:0], b[7:4]});
        job.chars[1] = b64le_pkg::b64_char({b[3:0], 2'b00});
        job.chars[2] = b64le_pkg::CHAR_PAD;
        job.chars[3] = b64le_pkg::CHAR_CR;
        job.chars[4] = b64le_pkg::CHAR_LF;
        job.count = fin ? b64le_pkg::CountW'(5) : b64le_pkg::CountW'(1);
        carry_bits_next = b[3:0];
        group_position_next = b64le_pkg::GRP_THIRD;
      end
      b64le_pkg::GRP_THIRD: begin
        // two symbols, then optional line break, then optional closing break
        job.chars[0] = b64le_pkg::b64_char({carry_bits, b[7:6]});
        job.chars[1] = b64le_pkg::b64_char(b[5:0]);
        job.count = b64le_pkg::CountW'(2) + (brk ? b64le_pkg::CountW'(2) : '0)
                    + (fin ? b64le_pkg::CountW'(2) : '0);
        carry_bits_next = '0;
        group_position_next = b64le_pkg::GRP_FIRST;
        line_length_next = brk ? 8'd0 : grown_len;
      end
      default: begin
        job.chars[0] = b64le_pkg::b64_char(b[7:2]);
        job.chars[1] = b64le_pkg::b64_char({b[1:0], 4'b0000});
        job.chars[2] = b64le_pkg::CHAR_PAD;
        job.chars[3] = b64le_pkg::CHAR_PAD;
        job.chars[4] = b64le_pkg::CHAR_CR;
        job.chars[5] = b64le_pkg::CHAR_LF;
        job.count = fin ? b64le_pkg::CountW'(6) : b64le_pkg::CountW'(1);
        carry_bits_next = {2'b00, b[1:0]};
        group_position_next = b64le_pkg::GRP_SECOND;
      end
    endcase
    if (fin) begin
      group_position_next = b64le_pkg::GRP_FIRST;
      carry_bits_next = '0;
      line_length_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= b64le_pkg::GRP_FIRST;
      carry_bits <= '0;
      line_length <= '0;
      line_limit <= b64le_pkg::DefaultLineLimit;
    end else begin
      if (accept) begin
        group_position <= group_position_next;
        carry_bits <= carry_bits_next;
        line_length <= line_length_next;
      end
      if (cfg_write) begin
        line_limit <= cfg_data;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/b64le_fifo.sv
// short job queue between front and back
`default_nettype none
module b64le_fifo #(
  parameter int unsigned JOB_DEPTH = b64le_pkg::DefaultJobDepth
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire b64le_pkg::job_t wr_job,
  input  wire logic            rd_en,
  output b64le_pkg::job_t      rd_job,
  output logic                 full,
  output logic                 empty
);

  localparam int unsigned PtrW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(JOB_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(JOB_DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(JOB_DEPTH);

  b64le_pkg::job_t slots [JOB_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] used;
  logic            do_wr, do_rd;

  assign full = (used == DepthCnt);
  assign empty = (used == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        used <= used + CntW'(1);
      end else if (do_rd && !do_wr) begin
        used <= used - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/b64le_back.sv
// back end: holds one job and hands its characters out one per pop
`default_nettype none
module b64le_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             job_empty,
  input  wire b64le_pkg::job_t  job_in,
  output logic                  job_take,
  input  wire logic             pop,
  output logic                  empty,
  output b64le_pkg::out_item_t  out_item
);

  b64le_pkg::job_t               cur;
  logic                          busy;
  logic [b64le_pkg::CountW-1:0]  idx;
  logic                          last_char;
  logic                          popped;

  assign last_char = (idx == cur.count - b64le_pkg::CountW'(1));
  assign popped = pop && busy;
  assign job_take = !job_empty && (!busy || (popped && last_char));
  assign empty = !busy;
  assign out_item.out_char = cur.chars[idx];
  assign out_item.run_last = last_char;

  always_ff @(posedge clk) begin
    if (job_take) begin
      cur <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else begin
      if (job_take) begin
        busy <= 1'b1;
        idx <= '0;
      end else if (popped) begin
        if (last_char) begin
          busy <= 1'b0;
          idx <= '0;
        end else begin
          idx <= idx + b64le_pkg::CountW'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/base64_line_encoder.sv
// top level of the base64 line encoder: front end, job queue and character back end
//
//  channel      direction  handshake                      payload
//  input bytes  in         push / full                    in_item (data_byte, final_byte)
//  characters   out        empty / pop                    out_item (out_char, run_last)
//  line limit   in         line_limit_valid / _ready      line_limit (8 bits, reset 76)
//
// a byte is taken whenever the job queue has room; the front end turns it into a
// job of one to six characters in the cycle it is taken.
// the back end hands out one character per cycle while pop is high, so the character
// port sets throughput: each byte needs one pop per character it causes.
// rst is synchronous and clears group position, line length, the queue and the
// back end; line_limit returns to 76. no clearing pass is needed.
// a stalled pop only backs up the queue; push keeps going until it fills.
`default_nettype none
module base64_line_encoder #(
  parameter int unsigned JOB_DEPTH = b64le_pkg::DefaultJobDepth
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // byte input
  input  wire logic                 push,
  output logic                      full,
  input  wire b64le_pkg::in_item_t  in_item,
  // character output
  output logic                      empty,
  input  wire logic                 pop,
  output b64le_pkg::out_item_t      out_item,
  // line limit write channel
  input  wire logic                 line_limit_valid,
  output logic                      line_limit_ready,
  input  wire logic [7:0]           line_limit
);

  b64le_pkg::job_t front_job;
  b64le_pkg::job_t queue_job;
  logic            queue_full;
  logic            queue_empty;
  logic            job_take;
  logic            accept;

  // register is always writable
  assign line_limit_ready = 1'b1;
  assign full = queue_full;
  assign accept = push && !queue_full;

  // classify each byte and build its character job
  b64le_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_item   (in_item),
    .cfg_write (line_limit_valid),
    .cfg_data  (line_limit),
    .job       (front_job)
  );

  // decouples byte intake from character output
  b64le_fifo #(
    .JOB_DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (accept),
    .wr_job (front_job),
    .rd_en  (job_take),
    .rd_job (queue_job),
    .full   (queue_full),
    .empty  (queue_empty)
  );

  // serialize characters, one per pop
  b64le_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (queue_empty),
    .job_in    (queue_job),
    .job_take  (job_take),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

>>> test/tb_top.sv
// testbench of the base64 line encoder: random messages, predicted characters, checked in order
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // run length: watchdog limit and stimulus sizes
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomBytes = 480;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned PhaseBytes = 60;

  // predicts the characters of each accepted byte and checks the port against them
  class char_scoreboard;
    string                 alphabet;
    logic [7:0]            limit;
    logic [1:0]            group_pos;
    logic [3:0]            carry;
    logic [7:0]            line_len;
    b64le_pkg::out_item_t  expected_chars[$];
    int unsigned           errors;

    function new();
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      errors = 0;
      limit = b64le_pkg::DefaultLineLimit;
      group_pos = b64le_pkg::GRP_FIRST;
      carry = 4'd0;
      line_len = 8'd0;
    endfunction

    function void set_limit(input logic [7:0] value);
      limit = value;
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction

    function void push_char(input logic [7:0] c);
      b64le_pkg::out_item_t it;
      it.out_char = c;
      it.run_last = 1'b0;
      expected_chars.push_back(it);
    endfunction

    function void push_sextet(input logic [5:0] six);
      push_char(alphabet[six]);
    endfunction

    function void push_eol();
      push_char(b64le_pkg::CHAR_CR);
      push_char(b64le_pkg::CHAR_LF);
    endfunction

    // one accepted byte: expected characters go to the back of the queue
    function void note_byte(input b64le_pkg::in_item_t item);
      logic [7:0] b;
      logic       fin;
      b = item.data_byte;
      fin = item.final_byte;
      case (group_pos)
        b64le_pkg::GRP_SECOND: begin
          push_sextet({carry[1:0], b[7:4]});
          carry = b[3:0];
          group_pos = b64le_pkg::GRP_THIRD;
          if (fin) begin
            push_sextet({carry, 2'b00});
            push_char(b64le_pkg::CHAR_PAD);
            push_eol();
          end
        end
        b64le_pkg::GRP_THIRD: begin
          push_sextet({carry, b[7:6]});
          push_sextet(b[5:0]);
          carry = 4'd0;
          group_pos = b64le_pkg::GRP_FIRST;
          line_len = line_len + 8'd4;
          if (int'(line_len) + 3 >= int'(limit)) begin
            push_eol();
            line_len = 8'd0;
          end
          if (fin) begin
            push_eol();
          end
        end
        default: begin
          push_sextet(b[7:2]);
          carry = {2'b00, b[1:0]};
          group_pos = b64le_pkg::GRP_SECOND;
          if (fin) begin
            push_sextet({b[1:0], 4'b0000});
            push_char(b64le_pkg::CHAR_PAD);
            push_char(b64le_pkg::CHAR_PAD);
            push_eol();
          end
        end
      endcase
      if (fin) begin
        group_pos = b64le_pkg::GRP_FIRST;
        carry = 4'd0;
        line_len = 8'd0;
      end
      expected_chars[expected_chars.size() - 1].run_last = 1'b1;
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_char(input b64le_pkg::out_item_t got);
      b64le_pkg::out_item_t want;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected char %h run_last %b", got.out_char, got.run_last));
        return;
      end
      want = expected_chars.pop_front();
      if (got.out_char !== want.out_char) begin
        report($sformatf("out_char %h, expected %h", got.out_char, want.out_char));
      end
      if (got.run_last !== want.run_last) begin
        report($sformatf("run_last %b, expected %b (char %h)",
                         got.run_last, want.run_last, want.out_char));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  b64le_pkg::in_item_t   in_item = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  b64le_pkg::out_item_t  out_item;
  logic                  line_limit_valid = 1'b0;
  logic                  line_limit_ready;
  logic [7:0]            line_limit = b64le_pkg::DefaultLineLimit;

  char_scoreboard sb;

  // idle rates in percent (per byte sent, per cycle popped), changed per phase so some phases run flat out
  int unsigned send_idle_pct = 0;
  int unsigned pop_idle_pct = 0;
  // last stretch of the run: no idling on either side
  bit          quiet_end = 1'b0;
  int unsigned pop_hold = 0;

  always #5 clk = ~clk;

  base64_line_encoder DUT (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .in_item          (in_item),
    .empty            (empty),
    .pop              (pop),
    .out_item         (out_item),
    .line_limit_valid (line_limit_valid),
    .line_limit_ready (line_limit_ready),
    .line_limit       (line_limit)
  );

  // character side: check what was taken at this edge, then pick pop for the next one
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      sb.check_char(out_item);
    end
    if (pop_hold > 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else if (!quiet_end && pop_idle_pct > 0 && $urandom_range(0, 99) < pop_idle_pct) begin
      // random stall burst, this cycle included
      pop_hold = $urandom_range(1, 12) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // push stays high when items follow back to back; only a gap or a drain lowers it
  task automatic send_byte(input logic [7:0] b, input logic fin);
    b64le_pkg::in_item_t it;
    it.data_byte = b;
    it.final_byte = fin;
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_byte(it);
    if (!quiet_end && send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // hold off the sender until every predicted character has been popped
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // only called with the block idle; the extra edge keeps valid from toggling in one step
  task automatic write_limit(input logic [7:0] value);
    line_limit_valid <= 1'b1;
    line_limit <= value;
    @(posedge clk);
    while (!line_limit_ready) @(posedge clk);
    sb.set_limit(value);
    line_limit_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random content, final flag on the last byte, an occasional mid-message drain
  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
      if (i != len - 1 && $urandom_range(0, 99) < 2) begin
        drain();
      end
    end
  endtask

  initial begin
    int unsigned random_sent;
    int unsigned phase_sent;
    int unsigned phase_num;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  lim;

    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, default limit of 76
    // single byte messages: two pads, all-zero and all-one bits
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // two byte message: one pad
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    // full final group, no padding
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    drain();

    // lowest legal limit: the second group closes the line and the message ends there,
    // so the last byte gives its two characters plus two line ends (empty line)
    write_limit(8'd8);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b1);
    drain();

    // limit below range: every full group is followed by a line end
    write_limit(8'd0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b1);
    drain();

    // random phases, each one starting from an idle block with a new limit
    random_sent = 0;
    phase_num = 0;
    while (random_sent < RandomBytes) begin
      drain();
      case (phase_num)
        0: lim = 8'd255;
        1: lim = 8'd8;
        2: lim = 8'd3;
        3: lim = 8'd255;
        default: lim = 8'($urandom_range(8, 255));
      endcase
      write_limit(lim);
      pick = $urandom_range(0, 2);
      send_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 40;
      pick = $urandom_range(0, 2);
      pop_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 40;
      phase_sent = 0;
      while (phase_sent < PhaseBytes && random_sent < RandomBytes) begin
        if (random_sent >= RandomBytes * 85 / 100) begin
          quiet_end = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          len = $urandom_range(1, 12);
        end else if (pick < 95) begin
          len = $urandom_range(13, 60);
        end else begin
          len = $urandom_range(61, 200);
        end
        // at the top limit a line only closes after 63 groups
        if (lim == 8'd255 && phase_sent == 0) begin
          len = 200;
        end
        // keep the total close to the planned byte count
        if (len > RandomBytes - random_sent) begin
          len = RandomBytes - random_sent;
        end
        send_message(len);
        phase_sent += len;
        random_sent += len;
      end
      phase_num++;
    end

    // let the last characters out, then watch for strays
    drain();
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
